/* design/annexb_pkg.sv */
package annexb_pkg;

  localparam int unsigned MaxResults = 4;

  localparam logic [4:0] NalTypeMask = 5'h1f;
  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteStart = 8'h01;
  localparam logic [7:0] ByteEmul = 8'h03;

  localparam logic KindPayload = 1'b0;
  localparam logic KindEnd = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic [4:0] nal_type;
    logic       is_header;
    logic       run_last;
  } out_item_t;

endpackage

/* design/annexb_nal_extractor.sv */
// Annex B NAL extractor: takes one stream byte per item and gives payload bytes, a header
// flag with the captured NAL unit type, and an end marker when a NAL unit closes. Every
// item is worked out combinationally into a registered result bank of up to four entries,
// shown one entry per cycle on the output while it is not stalled. An item with zero or
// one result lets the next item in on the following cycle unless the output stalls, so a
// plain byte stream runs at one byte per clock; an item that releases held zeros or closes
// a unit gives up to four results and holds the input while the bank drains.
// Configuration is taken in any cycle and must only be written while the block is idle.
module annexb_nal_extractor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  annexb_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output annexb_pkg::out_item_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i
);
  import annexb_pkg::*;

  typedef struct packed {
    logic [1:0] zero_run;
    logic [1:0] held_zeros;
    logic       inside_nal;
    logic       expect_header;
    logic [4:0] current_type;
  } state_t;

  typedef struct packed {
    state_t    st;
    logic      valid;
    out_item_t item;
  } emit_t;

  function automatic emit_t emit_payload(state_t s, logic [7:0] b);
    emit_t r;
    r.st = s;
    r.valid = 1'b0;
    r.item = '0;
    if (s.inside_nal) begin
      r.valid = 1'b1;
      if (s.expect_header) begin
        r.st.current_type = b[4:0] & NalTypeMask;
        r.st.expect_header = 1'b0;
        r.st.zero_run = 2'd0;
        r.item.is_header = 1'b1;
      end else if (b == ByteZero) begin
        if (s.zero_run != 2'd3) begin
          r.st.zero_run = s.zero_run + 2'd1;
        end
      end else begin
        r.st.zero_run = 2'd0;
      end
      r.item.kind = KindPayload;
      r.item.out_byte = b;
      r.item.nal_type = r.st.current_type;
      r.item.run_last = 1'b0;
    end
    return r;
  endfunction

  state_t    state_q, state_d;
  logic      emul_en_q;
  out_item_t bank_q [MaxResults];
  out_item_t res [MaxResults];
  logic [2:0] cnt_q, n;
  logic [1:0] rd_q;
  logic       pop, last, accept;
  emit_t      e;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o = bank_q[rd_q];
  assign pop = out_valid_o && !out_stall_i;
  assign last = (rd_q == 2'(cnt_q - 3'd1));
  assign in_stall_o = out_valid_o && !(pop && last);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    n = 3'd0;
    e = '0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '0;
    end
    if (in_data_i.end_of_stream) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < state_q.held_zeros) begin
          e = emit_payload(state_d, ByteZero);
          state_d = e.st;
          if (e.valid) begin
            res[n[1:0]] = e.item;
            n = n + 3'd1;
          end
        end
      end
      if (state_d.inside_nal) begin
        res[n[1:0]].kind = KindEnd;
        res[n[1:0]].nal_type = state_d.current_type;
        n = n + 3'd1;
      end
      state_d = '0;
    end else if (in_data_i.in_byte == ByteZero) begin
      if (state_q.held_zeros != 2'd3) begin
        state_d.held_zeros = state_q.held_zeros + 2'd1;
      end else begin
        e = emit_payload(state_d, ByteZero);
        state_d = e.st;
        if (e.valid) begin
          res[0] = e.item;
          n = 3'd1;
        end
      end
    end else if (in_data_i.in_byte == ByteStart && state_q.held_zeros >= 2'd2) begin
      if (state_q.inside_nal) begin
        res[0].kind = KindEnd;
        res[0].nal_type = state_q.current_type;
        n = 3'd1;
      end
      state_d.inside_nal = 1'b1;
      state_d.expect_header = 1'b1;
      state_d.current_type = 5'd0;
      state_d.zero_run = 2'd0;
      state_d.held_zeros = 2'd0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < state_q.held_zeros) begin
          e = emit_payload(state_d, ByteZero);
          state_d = e.st;
          if (e.valid) begin
            res[n[1:0]] = e.item;
            n = n + 3'd1;
          end
        end
      end
      state_d.held_zeros = 2'd0;
      if (in_data_i.in_byte == ByteEmul && emul_en_q && state_d.inside_nal &&
          !state_d.expect_header && state_d.zero_run >= 2'd2) begin
        state_d.zero_run = 2'd0;
      end else begin
        e = emit_payload(state_d, in_data_i.in_byte);
        state_d = e.st;
        if (e.valid) begin
          res[n[1:0]] = e.item;
          n = n + 3'd1;
        end
      end
    end
    if (n != 3'd0) begin
      res[2'(n - 3'd1)].run_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      emul_en_q <= 1'b1;
      cnt_q <= 3'd0;
      rd_q <= 2'd0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        emul_en_q <= cfg_data_i;
      end
      if (accept) begin
        state_q <= state_d;
        cnt_q <= n;
        rd_q <= 2'd0;
      end else if (pop) begin
        if (last) begin
          cnt_q <= 3'd0;
          rd_q <= 2'd0;
        end else begin
          rd_q <= rd_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < MaxResults; i++) begin
        bank_q[i] <= res[i];
      end
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import annexb_pkg::*;

  class nal_scoreboard;
    out_item_t expected_q[$];
    out_item_t step_q[$];
    logic [1:0] zero_run;
    logic [1:0] held_zeros;
    logic inside_nal;
    logic expect_header;
    logic [4:0] cur_type;
    logic emul_en;
    int unsigned errors;
    int unsigned items_seen;
    int unsigned results_seen;
    int unsigned headers_seen;
    int unsigned markers_seen;
    int unsigned removals_seen;

    function new();
      zero_run = '0;
      held_zeros = '0;
      inside_nal = 1'b0;
      expect_header = 1'b0;
      cur_type = '0;
      emul_en = 1'b1;
    endfunction

    function void add_result(logic kind, logic [7:0] b, logic hdr);
      out_item_t r;
      r.kind = kind;
      r.out_byte = b;
      r.nal_type = cur_type;
      r.is_header = hdr;
      r.run_last = 1'b0;
      step_q.insert(step_q.size(), r);
    endfunction

    function void add_payload(logic [7:0] b);
      logic hdr;
      hdr = 1'b0;
      if (!inside_nal) return;
      if (expect_header) begin
        cur_type = b[4:0] & NalTypeMask;
        expect_header = 1'b0;
        zero_run = '0;
        hdr = 1'b1;
        headers_seen++;
      end else if (b == ByteZero) begin
        if (zero_run != 2'd3) zero_run++;
      end else begin
        zero_run = '0;
      end
      add_result(KindPayload, b, hdr);
    endfunction

    function void flush_zeros();
      while (held_zeros != 2'd0) begin
        held_zeros--;
        add_payload(ByteZero);
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t last;
      step_q.delete();
      items_seen++;
      if (it.end_of_stream) begin
        flush_zeros();
        if (inside_nal) begin
          add_result(KindEnd, ByteZero, 1'b0);
          markers_seen++;
        end
        inside_nal = 1'b0;
        expect_header = 1'b0;
        zero_run = '0;
        held_zeros = '0;
        cur_type = '0;
      end else if (it.in_byte == ByteZero) begin
        if (held_zeros != 2'd3) held_zeros++;
        else add_payload(ByteZero);
      end else if (it.in_byte == ByteStart && held_zeros >= 2'd2) begin
        if (inside_nal) begin
          add_result(KindEnd, ByteZero, 1'b0);
          markers_seen++;
        end
        inside_nal = 1'b1;
        expect_header = 1'b1;
        cur_type = '0;
        zero_run = '0;
        held_zeros = '0;
      end else begin
        flush_zeros();
        if (it.in_byte == ByteEmul && emul_en && inside_nal && !expect_header &&
            zero_run >= 2'd2) begin
          zero_run = '0;
          removals_seen++;
        end else begin
          add_payload(it.in_byte);
        end
      end
      if (step_q.size() != 0) begin
        last = step_q[step_q.size() - 1];
        last.run_last = 1'b1;
        step_q[step_q.size() - 1] = last;
      end
      foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      string bad;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("testbench: unexpected item kind=%0d byte=%02h type=%0d hdr=%0d last=%0d",
                   got.kind, got.out_byte, got.nal_type, got.is_header, got.run_last);
        return;
      end
      exp = expected_q.pop_front();
      bad = "";
      if (got.kind !== exp.kind) bad = {bad, " kind"};
      if (got.out_byte !== exp.out_byte) bad = {bad, " out_byte"};
      if (got.nal_type !== exp.nal_type) bad = {bad, " nal_type"};
      if (got.is_header !== exp.is_header) bad = {bad, " is_header"};
      if (got.run_last !== exp.run_last) bad = {bad, " run_last"};
      if (bad != "") begin
        errors++;
        if (errors <= 10) begin
          $display("testbench: mismatch in%s at %0t", bad, $realtime);
          $display("  expected kind=%0d byte=%02h type=%0d hdr=%0d last=%0d",
                   exp.kind, exp.out_byte, exp.nal_type, exp.is_header, exp.run_last);
          $display("  actual   kind=%0d byte=%02h type=%0d hdr=%0d last=%0d",
                   got.kind, got.out_byte, got.nal_type, got.is_header, got.run_last);
        end
      end
    endfunction
  endclass

  localparam int StreamEnd = -1;
  localparam int DirectedSeq [28] = '{
    8'hAA, ByteZero, StreamEnd,
    ByteZero, ByteZero, ByteStart, ByteEmul,
    ByteZero, ByteZero, ByteEmul,
    ByteZero, ByteZero, ByteZero, ByteZero, ByteStart,
    ByteZero, ByteZero, ByteStart,
    ByteZero, 8'h7F,
    ByteZero, ByteZero, ByteZero, 8'hFF,
    ByteZero, ByteStart,
    ByteZero, StreamEnd
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent = 0;

  nal_scoreboard sb = new();

  annexb_nal_extractor dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (cfg_valid && cfg_ready) sb.emul_en = cfg_data;
    end
  end

  task automatic drive_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drive_byte(input logic [7:0] b);
    in_item_t it;
    it.in_byte = b;
    it.end_of_stream = 1'b0;
    drive_item(it);
  endtask

  task automatic drive_eos();
    in_item_t it;
    it.in_byte = 8'($urandom_range(255));
    it.end_of_stream = 1'b1;
    drive_item(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_emul(input logic en);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly start code, header and payload rich in zero and 03 bytes, with some
  // raw noise and short zero runs that do not make a start code.
  task automatic drive_random_unit();
    int unsigned sel;
    int unsigned zeros;
    int unsigned len;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 10) begin
      len = $urandom_range(6, 1);
      repeat (len) drive_byte(8'($urandom_range(255)));
      return;
    end
    if (sel < 18) zeros = 1;
    else if (sel < 60) zeros = 2;
    else if (sel < 85) zeros = 3;
    else zeros = $urandom_range(5, 4);
    repeat (zeros) drive_byte(ByteZero);
    drive_byte(ByteStart);
    sel = $urandom_range(99);
    if (sel < 10) drive_byte(ByteZero);
    else if (sel < 20) drive_byte(ByteEmul);
    else drive_byte(8'($urandom_range(255)));
    len = $urandom_range(14);
    repeat (len) begin
      sel = $urandom_range(99);
      if (sel < 35) b = ByteZero;
      else if (sel < 50) b = ByteEmul;
      else if (sel < 55) b = ByteStart;
      else b = 8'($urandom_range(255));
      drive_byte(b);
    end
    if ($urandom_range(99) < 12) drive_eos();
  endtask

  initial begin
    int unsigned target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_emul(1'b1);
    foreach (DirectedSeq[i]) begin
      if (DirectedSeq[i] == StreamEnd) drive_eos();
      else drive_byte(8'(DirectedSeq[i]));
    end
    for (int phase = 0; phase < 4; phase++) begin
      write_emul(phase[0]);
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 61;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 61;
        end
        default: begin
          send_idle_pct = 6;
          recv_stall_pct = 6;
        end
      endcase
      target = items_sent + 40;
      while (items_sent < target) drive_random_unit();
    end
    settle();
    $display("testbench: %0d items in, %0d results out (%0d headers, %0d end markers)",
             sb.items_seen, sb.results_seen, sb.headers_seen, sb.markers_seen);
    $display("testbench: %0d emulation bytes removed, removal on and off, four stall mixes",
             sb.removals_seen);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: %0d mismatches", sb.errors);
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

/* files.f */
design/annexb_pkg.sv
design/annexb_nal_extractor.sv
tb/testbench.sv
